// ----- rtl/gzl_pkg.sv -----
// Types, codes and helper functions for the GF(q) Zech-log arithmetic unit.
// Used by gf_zech_log_alu; no dependencies.
package gzl_pkg;

  localparam logic [15:0] ZERO_CODE = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_INV    = 3'd5,
    ACT_NEG    = 3'd6,
    ACT_MULADD = 3'd7
  } action_t;

  typedef enum logic [0:0] {
    REG_ORDER_MINUS_ONE = 1'b0,
    REG_MINUS_ONE_LOG   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [15:0] operand_c;
    logic [15:0] table_index;
    logic [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        error;
  } out_item_t;

  // one remainder lane: source word and partial remainder
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] r;
  } lane_t;

  typedef struct packed {
    action_t         action;
    lane_t [3:0]     lane;
    logic [15:0]     idx;
    logic [15:0]     val;
  } front_t;

  typedef struct packed {
    logic        load;
    logic [15:0] idx;
    logic [15:0] val;
    logic        add_path;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] res;
    logic        err;
  } mid_t;

  typedef struct packed {
    logic        load;
    logic [15:0] idx;
    logic [15:0] val;
    logic        tab;
    logic [15:0] addr;
    logic        oob;
    logic [15:0] lo;
    logic [15:0] res;
    logic        err;
  } look_t;

  typedef struct packed {
    logic        tab;
    logic        oob;
    logic [15:0] lo;
    logic [15:0] res;
    logic        err;
  } tail_t;

  typedef struct packed {
    tail_t       t;
    logic        zz;
    lane_t       z;
  } zlane_t;

  // four restoring remainder steps; r < m on entry and exit, m nonzero
  function automatic logic [15:0] mod_step4(input logic [15:0] r, input logic [3:0] bits,
                                            input logic [15:0] m);
    logic [16:0] t;
    logic [15:0] q;
    q = r;
    for (int i = 3; i >= 0; i--) begin
      t = {q, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      q = t[15:0];
    end
    return q;
  endfunction

  // (a + b) mod m for a, b < m
  function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] m);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[15:0];
  endfunction

endpackage

// ----- rtl/gzl_table_ram.sv -----
// Zech table storage: one write port, one registered read port.
// Depends on nothing but its parameters.
module gzl_table_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gf_zech_log_alu.sv -----
// GF(q) arithmetic unit on Zech-log operands, 12-stage pipeline.
// Depends on gzl_pkg and gzl_table_ram.
//
//   channel | signals                           | direction
//   in      | in_valid, in_ready, in_item       | request transaction
//   out     | out_valid, out_ready, out_item    | one result per request
//   cfg     | cfg_valid, cfg_ready, cfg_index,  | register write, always ready
//           | cfg_data                          |
//
// One transaction per cycle while the output is not stalled.
// Stages 1-4 reduce the operands mod q-1 (four remainder bits per stage),
// stage 5 forms direct results and adder operands, stage 6 forms the table
// address, stage 7 reads or writes the table, stages 8-11 reduce the table
// word, stage 12 holds the result.
// Reset clears valid bits and presets config registers; the table has no reset.
// A stall fills empty stages first, then holds every stage in place.
module gf_zech_log_alu #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gzl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gzl_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  gzl_pkg::cfg_reg_t  cfg_index,
  input  logic [15:0]        cfg_data
);
  import gzl_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int NSTG   = 12;
  localparam int LA     = 0;
  localparam int LB     = 1;
  localparam int LC     = 2;
  localparam int LN     = 3;

  logic [15:0] modulus;
  logic [15:0] minus_one_log;

  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  front_t    fr      [1:4];
  front_t    fr_next [1:4];
  mid_t      mid;
  mid_t      mid_next;
  look_t     look;
  look_t     look_next;
  tail_t     tail;
  zlane_t    zl      [8:11];
  zlane_t    zl_next [8:11];
  out_item_t res_q;
  out_item_t res_next;

  logic              ram_we;
  logic [15:0]       ram_rdata;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= 16'd1;
      minus_one_log <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORDER_MINUS_ONE: modulus <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        REG_MINUS_ONE_LOG:   minus_one_log <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid chain
  always_comb begin
    en[NSTG] = !vld[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTG];
  assign out_item  = res_q;

  // stages 1-4: operand reduction
  always_comb begin
    fr_next[1].action      = in_item.action;
    fr_next[1].idx         = in_item.table_index;
    fr_next[1].val         = in_item.table_value;
    fr_next[1].lane[LA].x  = in_item.operand_a;
    fr_next[1].lane[LB].x  = in_item.operand_b;
    fr_next[1].lane[LC].x  = in_item.operand_c;
    fr_next[1].lane[LN].x  = minus_one_log;
    for (int l = 0; l < 4; l++) begin
      fr_next[1].lane[l].r = mod_step4(16'd0, fr_next[1].lane[l].x[15:12], modulus);
    end
    for (int k = 2; k <= 4; k++) begin
      fr_next[k] = fr[k-1];
      for (int l = 0; l < 4; l++) begin
        fr_next[k].lane[l].r = mod_step4(fr[k-1].lane[l].r,
                                         fr[k-1].lane[l].x[15-4*(k-1) -: 4], modulus);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= 4; k++) begin
      if (en[k]) begin
        fr[k] <= fr_next[k];
      end
    end
  end

  // stage 5: direct results and adder operands
  always_comb begin
    logic        za, zb, zc;
    logic [15:0] a, b, c, n;
    za = (fr[4].lane[LA].x == ZERO_CODE);
    zb = (fr[4].lane[LB].x == ZERO_CODE);
    zc = (fr[4].lane[LC].x == ZERO_CODE);
    a  = za ? ZERO_CODE : fr[4].lane[LA].r;
    b  = zb ? ZERO_CODE : fr[4].lane[LB].r;
    c  = zc ? ZERO_CODE : fr[4].lane[LC].r;
    n  = fr[4].lane[LN].r;

    mid_next          = '0;
    mid_next.idx      = fr[4].idx;
    mid_next.val      = fr[4].val;
    case (fr[4].action)
      ACT_LOAD: begin
        mid_next.load = 1'b1;
      end
      ACT_ADD: begin
        mid_next.add_path = 1'b1;
        mid_next.x        = a;
        mid_next.y        = b;
      end
      ACT_SUB: begin
        if (zb) begin
          mid_next.res = a;
        end else if (a == b) begin
          mid_next.res = ZERO_CODE;
        end else begin
          mid_next.add_path = 1'b1;
          mid_next.x        = a;
          mid_next.y        = add_mod(b, n, modulus);
        end
      end
      ACT_MUL: begin
        mid_next.res = (za || zb) ? ZERO_CODE : add_mod(a, b, modulus);
      end
      ACT_DIV: begin
        if (zb) begin
          mid_next.res = ZERO_CODE;
          mid_next.err = 1'b1;
        end else if (za) begin
          mid_next.res = ZERO_CODE;
        end else if (a >= b) begin
          mid_next.res = a - b;
        end else begin
          mid_next.res = modulus - (b - a);
        end
      end
      ACT_INV: begin
        if (za) begin
          mid_next.res = ZERO_CODE;
          mid_next.err = 1'b1;
        end else if (a == 16'd0) begin
          mid_next.res = 16'd0;
        end else begin
          mid_next.res = modulus - a;
        end
      end
      ACT_NEG: begin
        mid_next.res = za ? ZERO_CODE : add_mod(a, n, modulus);
      end
      ACT_MULADD: begin
        mid_next.add_path = 1'b1;
        mid_next.x        = a;
        mid_next.y        = (zb || zc) ? ZERO_CODE : add_mod(b, c, modulus);
      end
      default: begin
        mid_next.res = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mid <= mid_next;
    end
  end

  // stage 6: Zech table address
  always_comb begin
    logic [15:0] d;
    d               = 16'd0;
    look_next       = '0;
    look_next.load  = mid.load;
    look_next.idx   = mid.idx;
    look_next.val   = mid.val;
    look_next.res   = mid.res;
    look_next.err   = mid.err;
    if (mid.add_path) begin
      if (mid.y == ZERO_CODE) begin
        look_next.res = mid.x;
      end else if (mid.x == ZERO_CODE) begin
        look_next.res = mid.y;
      end else begin
        look_next.tab = 1'b1;
        if (mid.x >= mid.y) begin
          d            = mid.x - mid.y;
          look_next.lo = mid.y;
        end else begin
          d            = mid.y - mid.x;
          look_next.lo = mid.x;
        end
      end
    end
    look_next.addr = d;
    look_next.oob  = !({16'd0, d} < 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      look <= look_next;
    end
  end

  // stage 7: table access
  assign ram_we = en[7] && vld[6] && look.load && ({16'd0, look.idx} < 32'(TABLE_DEPTH));

  gzl_table_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (look.idx[ADDR_W-1:0]),
    .wdata (look.val),
    .re    (en[7]),
    .raddr (look.addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tail.tab <= look.tab;
      tail.oob <= look.oob;
      tail.lo  <= look.lo;
      tail.res <= look.res;
      tail.err <= look.err;
    end
  end

  // stages 8-11: table word reduction
  always_comb begin
    logic [15:0] zv;
    zv               = tail.oob ? 16'd0 : ram_rdata;
    zl_next[8].t     = tail;
    zl_next[8].zz    = (zv == ZERO_CODE);
    zl_next[8].z.x   = zv;
    zl_next[8].z.r   = mod_step4(16'd0, zv[15:12], modulus);
    for (int k = 9; k <= 11; k++) begin
      zl_next[k]     = zl[k-1];
      zl_next[k].z.r = mod_step4(zl[k-1].z.r, zl[k-1].z.x[15-4*(k-8) -: 4], modulus);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 8; k <= 11; k++) begin
      if (en[k]) begin
        zl[k] <= zl_next[k];
      end
    end
  end

  // stage 12: result register
  always_comb begin
    res_next.error = zl[11].t.err;
    if (!zl[11].t.tab) begin
      res_next.result = zl[11].t.res;
    end else if (zl[11].zz) begin
      res_next.result = ZERO_CODE;
    end else begin
      res_next.result = add_mod(zl[11].z.r, zl[11].t.lo, modulus);
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      res_q <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_err_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error |-> out_item.result == ZERO_CODE)
    else $error("error flag with nonzero result");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result != ZERO_CODE |-> out_item.result < modulus)
    else $error("result not reduced mod q-1");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");
`endif

endmodule
